[rtl/gcs_pkg.sv]
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types and constants for the gamma contrast stretch block.
// ----------------------------------------------------------------------------
package gcs_pkg;

    localparam int unsigned FRACTION_BITS_DEF = 16;
    localparam int unsigned PIX_W             = 8;
    localparam int unsigned GAMMA_W           = 7;

    localparam logic [PIX_W-1:0]   PIX_MAX      = 8'hFF;
    localparam logic [PIX_W-1:0]   DARK_RESET   = 8'hFF;
    localparam logic [PIX_W-1:0]   BRIGHT_RESET = 8'h00;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET  = 7'd1;

    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_MAP  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/gcs_qmul.sv]
// ----------------------------------------------------------------------------
// gcs_qmul
// Shared fixed-point multiplier with round-to-nearest on the fraction bits.
// ----------------------------------------------------------------------------
module gcs_qmul #(
    parameter int unsigned FRACTION_BITS = gcs_pkg::FRACTION_BITS_DEF
) (
    input  logic [FRACTION_BITS:0] i_a,
    input  logic [FRACTION_BITS:0] i_b,
    output logic [FRACTION_BITS:0] o_y
);
    import gcs_pkg::*;

    localparam int unsigned PW = 2 * FRACTION_BITS + 2;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

    logic [PW-1:0] prod;
    logic [PW-1:0] rnd;

    assign prod = PW'(i_a) * PW'(i_b);
    assign rnd  = prod + HALF;
    assign o_y  = rnd[2*FRACTION_BITS:FRACTION_BITS];

endmodule

[rtl/gcs_div.sv]
// ----------------------------------------------------------------------------
// gcs_div
// Restoring serial divider, one quotient bit per cycle, for the pixel ratio.
// ----------------------------------------------------------------------------
module gcs_div #(
    parameter int unsigned FRACTION_BITS = gcs_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [FRACTION_BITS+7:0]         i_num,
    input  logic [gcs_pkg::PIX_W-1:0]        i_den,
    output logic [FRACTION_BITS:0]           o_quot,
    output gcs_pkg::t_div_stat               o_stat
);
    import gcs_pkg::*;

    localparam int unsigned CW = $clog2(FRACTION_BITS + 1);
    localparam logic [CW-1:0] LAST = CW'(FRACTION_BITS);

    logic [PIX_W-1:0]       r_rem, n_rem;
    logic [FRACTION_BITS:0] r_sh,  n_sh;
    logic [PIX_W-1:0]       r_den, n_den;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [PIX_W:0]         trial;
    logic [PIX_W:0]         diff;
    logic                   fits;

    assign trial = {r_rem, r_sh[FRACTION_BITS]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_sh   = r_sh;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = {1'b0, i_num[FRACTION_BITS+7:FRACTION_BITS+1]};
            n_sh   = i_num[FRACTION_BITS:0];
            n_den  = i_den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
            n_sh  = {r_sh[FRACTION_BITS-1:0], fits};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_den <= n_den;
    end

    assign o_quot      = r_sh;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[rtl/gamma_contrast_stretch.sv]
// ----------------------------------------------------------------------------
// gamma_contrast_stretch
// Contrast stretch with integer gamma on 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries mode, frame_start, gray_in.
// A scan item (mode 0) updates the tracked darkest and brightest levels
// and gives no output; frame_start restarts tracking.
// A map item (mode 1) gives one output item (o_out_valid / i_out_stall):
// gray_out = 255 * ((p - min) / (max - min)) ^ gamma, and flat_range when
// max <= min (gray_out 0 then).
// A map item runs the serial divider for the ratio (skipped when the pixel
// lies outside the range), then one multiply step per gamma bit up to the
// highest set one, with a squaring step between them, on the shared
// multiplier, then a final scale step and a step that loads the output; the
// next item can be taken in the cycle after the result loads. Flat maps skip
// the divider and the multiplier.
// The input is stalled while a map item is in work. A finished result waits
// in the output register while the receiver stalls; the next item is taken
// meanwhile but cannot complete until that register frees.
// Gamma is set by APB at byte address 0; the user writes it only while idle.
// Reset: gamma 1, darkest 255, brightest 0, no output pending.
// ----------------------------------------------------------------------------
module gamma_contrast_stretch #(
    parameter int unsigned FRACTION_BITS = gcs_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic                          i_frame_start,
    input  logic [gcs_pkg::PIX_W-1:0]     i_gray_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gcs_pkg::PIX_W-1:0]     o_gray_out,
    output logic                          o_flat_range,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import gcs_pkg::*;

    localparam int unsigned QW = FRACTION_BITS + 1;
    localparam int unsigned NW = FRACTION_BITS + 8;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRACTION_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [GAMMA_W-1:0] r_gamma;
    logic [PIX_W-1:0]   r_dark, n_dark;
    logic [PIX_W-1:0]   r_bright, n_bright;
    logic [GAMMA_W-1:0] r_g, n_g;
    logic [QW-1:0]      r_acc, n_acc;
    logic [QW-1:0]      r_base, n_base;
    logic [PIX_W-1:0]   r_res, n_res;
    logic               r_flat, n_flat;
    logic               r_out_valid, n_out_valid;
    logic [PIX_W-1:0]   r_gray_out, n_gray_out;
    logic               r_flat_out, n_flat_out;

    logic               in_acc;
    logic               cfg_wr;
    logic               div_start;
    logic [NW-1:0]      div_num;
    logic [PIX_W-1:0]   span;
    logic [PIX_W-1:0]   offs;
    logic [QW-1:0]      div_quot;
    t_div_stat          div_stat;
    logic [QW-1:0]      mul_a;
    logic [QW-1:0]      mul_b;
    logic [QW-1:0]      mul_y;
    logic               out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32 - GAMMA_W){1'b0}}, r_gamma};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (cfg_wr) begin
            r_gamma <= pwdata[GAMMA_W-1:0];
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;

    assign span    = r_bright - r_dark;
    assign offs    = i_gray_in - r_dark;
    assign div_num = ({offs, {FRACTION_BITS{1'b0}}}) + NW'(span >> 1);

    gcs_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (span),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    always_comb begin
        mul_a = r_acc;
        mul_b = r_base;
        unique case (r_state)
            S_SQ:    mul_a = r_base;
            S_SCALE: begin
                mul_a = QW'(PIX_MAX);
                mul_b = r_acc;
            end
            default: mul_a = r_acc;
        endcase
    end

    gcs_qmul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_qmul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_y (mul_y)
    );

    always_comb begin
        n_state     = r_state;
        n_dark      = r_dark;
        n_bright    = r_bright;
        n_g         = r_g;
        n_acc       = r_acc;
        n_base      = r_base;
        n_res       = r_res;
        n_flat      = r_flat;
        n_out_valid = r_out_valid & i_out_stall;
        n_gray_out  = r_gray_out;
        n_flat_out  = r_flat_out;
        div_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_mode == MODE_SCAN) begin
                        if (i_frame_start) begin
                            n_dark   = i_gray_in;
                            n_bright = i_gray_in;
                        end else begin
                            if (i_gray_in < r_dark)   n_dark   = i_gray_in;
                            if (i_gray_in > r_bright) n_bright = i_gray_in;
                        end
                    end else begin
                        n_g   = r_gamma;
                        n_acc = ONE_Q;
                        if (r_bright <= r_dark) begin
                            n_flat  = 1'b1;
                            n_res   = '0;
                            n_state = S_DONE;
                        end else begin
                            n_flat = 1'b0;
                            if (i_gray_in <= r_dark) begin
                                n_base  = '0;
                                n_state = S_MUL;
                            end else if (i_gray_in >= r_bright) begin
                                n_base  = ONE_Q;
                                n_state = S_MUL;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_base  = (div_quot > ONE_Q) ? ONE_Q : div_quot;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_g[0]) n_acc = mul_y;
                n_state = (r_g[GAMMA_W-1:1] == '0) ? S_SCALE : S_SQ;
            end
            S_SQ: begin
                n_base  = mul_y;
                n_g     = r_g >> 1;
                n_state = S_MUL;
            end
            S_SCALE: begin
                n_res   = (mul_y > QW'(PIX_MAX)) ? PIX_MAX : mul_y[PIX_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_gray_out  = r_res;
                    n_flat_out  = r_flat;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dark      <= DARK_RESET;
            r_bright    <= BRIGHT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dark      <= n_dark;
            r_bright    <= n_bright;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g        <= n_g;
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_res      <= n_res;
        r_flat     <= n_flat;
        r_gray_out <= n_gray_out;
        r_flat_out <= n_flat_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_gray_out   = r_gray_out;
    assign o_flat_range = r_flat_out;

endmodule
